// ===== design/hpet_pkg.sv =====
// Shared types and constants for the event timer: command and timer-setting
// structs, operation and register codes, queue sizing.
// No dependencies.
package hpet_pkg;

  // Input operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register byte offsets (8-byte aligned)
  localparam logic [9:0] OFF_GCAP = 10'h000;
  localparam logic [9:0] OFF_GCFG = 10'h010;
  localparam logic [9:0] OFF_GIST = 10'h020;
  localparam logic [9:0] OFF_MCNT = 10'h0F0;

  // Word select inside a timer's 32-byte block
  localparam logic [1:0] SUB_CFG = 2'd0;
  localparam logic [1:0] SUB_CMP = 2'd1;

  // First timer block starts at 0x100, i.e. block number 8 of 32 bytes
  localparam logic [4:0] TIMER_BASE_BLK = 5'd8;
  localparam int         TIDX_W         = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_PER_MASK    = 2'd1;
  localparam logic [1:0] CFG_ROUTE_CAP   = 2'd2;

  localparam int PERIOD_FS_W = 27;
  localparam int PMASK_W     = 3;
  localparam int ROUTE_CAP_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int IRQ_W       = 3;

  // Command queue sizing
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_READ,
    CMD_WRITE,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_GCAP,
    TGT_GCFG,
    TGT_GIST,
    TGT_MCNT,
    TGT_TCFG,
    TGT_TCMP
  } reg_tgt_t;

  typedef struct packed {
    cmd_kind_t         kind;
    reg_tgt_t          tgt;
    logic [TIDX_W-1:0] tidx;
    logic [63:0]       data;
  } cmd_t;

  typedef struct packed {
    logic [4:0] route;
    logic       m32;
    logic       valset;
    logic       per;
    logic       enb;
    logic       level;
  } tset_t;

endpackage

// ===== design/hpet_front.sv =====
// Front end: decodes an incoming operation and byte offset into a command.
// Depends on hpet_pkg.
module hpet_front import hpet_pkg::*; #(
  parameter int NUM_TIMERS = 3
) (
  input  logic [1:0]  op,
  input  logic [9:0]  reg_offset,
  input  logic [63:0] write_data,
  output cmd_t        cmd
);

  logic [9:0]        off;
  logic [TIDX_W-1:0] blk;
  logic [1:0]        sub;

  // Drop the low three byte-offset bits; locate timer block and word
  assign off = {reg_offset[9:3], 3'b000};
  assign blk = reg_offset[9:5] - TIMER_BASE_BLK;
  assign sub = reg_offset[4:3];

  // Classify operation and target register
  always_comb begin
    cmd.kind = CMD_NOP;
    cmd.tgt  = TGT_NONE;
    cmd.tidx = blk;
    cmd.data = write_data;
    unique case (op)
      OP_TICK:  cmd.kind = CMD_TICK;
      OP_READ:  cmd.kind = CMD_READ;
      OP_WRITE: cmd.kind = CMD_WRITE;
      default:  cmd.kind = CMD_NOP;
    endcase
    if (off == OFF_GCAP) begin
      cmd.tgt = TGT_GCAP;
    end else if (off == OFF_GCFG) begin
      cmd.tgt = TGT_GCFG;
    end else if (off == OFF_GIST) begin
      cmd.tgt = TGT_GIST;
    end else if (off == OFF_MCNT) begin
      cmd.tgt = TGT_MCNT;
    end else if (reg_offset[9:8] != 2'b00 && 32'(blk) < NUM_TIMERS) begin
      if (sub == SUB_CFG) begin
        cmd.tgt = TGT_TCFG;
      end else if (sub == SUB_CMP) begin
        cmd.tgt = TGT_TCMP;
      end
    end
  end

endmodule

// ===== design/hpet_cmdq.sv =====
// Two-entry command queue between the decoder and the execution stage.
// Depends on hpet_pkg.
module hpet_cmdq import hpet_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = entry[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/hpet_back.sv =====
// Execution stage: holds counter and timer state, executes one command per
// cycle unless the output stalls, presenting the result in an output register. Depends on hpet_pkg.
module hpet_back import hpet_pkg::*; #(
  parameter int NUM_TIMERS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [PERIOD_FS_W-1:0] tick_period_fs,
  input  logic [PMASK_W-1:0]     periodic_capable_mask,
  input  logic [ROUTE_CAP_W-1:0] route_capability,
  input  logic                   q_nonempty,
  input  cmd_t                   cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            read_data,
  output logic [IRQ_W-1:0]       irq_level,
  output logic [IRQ_W-1:0]       fired
);

  localparam int TW = $clog2(NUM_TIMERS);
  localparam logic [4:0] NT_M1 = 5'(NUM_TIMERS - 1);

  // Architectural state; cnt_inc always holds main_count + 1
  logic [63:0]           main_count;
  logic [63:0]           cnt_inc;
  logic                  gen;
  logic                  legacy;
  logic [NUM_TIMERS-1:0] status;
  tset_t                 tset   [NUM_TIMERS];
  logic [63:0]           cmp    [NUM_TIMERS];
  logic [63:0]           period [NUM_TIMERS];

  logic [63:0]           main_count_next;
  logic [63:0]           cnt_inc_next;
  logic                  gen_next;
  logic                  legacy_next;
  logic [NUM_TIMERS-1:0] status_next;
  tset_t                 tset_next   [NUM_TIMERS];
  logic [63:0]           cmp_next    [NUM_TIMERS];
  logic [63:0]           period_next [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] cap;
  logic [NUM_TIMERS-1:0] hit;
  logic [63:0]           sum [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fire;
  logic [63:0]           rd_word;
  logic [63:0]           rd_result;
  logic [63:0]           wr_cmp;
  logic [IRQ_W-1:0]      irq_next;
  logic [TW-1:0]         ti;
  logic                  exec;

  assign ti    = cmd.tidx[TW-1:0];
  assign exec  = q_nonempty && (!out_valid || !out_stall);
  assign q_pop = exec;

  // Periodic capability per timer; only the low timers can have it
  always_comb begin
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if (n < PMASK_W) begin
        cap[n] = periodic_capable_mask[n[1:0]];
      end else begin
        cap[n] = 1'b0;
      end
    end
  end

  // Compare each comparator with the incremented count; form periodic sums
  always_comb begin
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if (tset[n].m32) begin
        hit[n] = (cnt_inc[31:0] == cmp[n][31:0]);
      end else begin
        hit[n] = (cnt_inc == cmp[n]);
      end
      sum[n] = cmp[n] + period[n];
    end
  end

  // Select the register word for a read
  always_comb begin
    rd_word = '0;
    unique case (cmd.tgt)
      TGT_GCAP: rd_word = {5'b0, tick_period_fs, 16'b0, 1'b1, 1'b0, 1'b1, NT_M1, 8'h01};
      TGT_GCFG: rd_word = {62'b0, legacy, gen};
      TGT_GIST: rd_word = 64'(status);
      TGT_MCNT: rd_word = main_count;
      TGT_TCFG: rd_word = {route_capability, 18'b0, tset[ti].route, tset[ti].m32, 1'b0,
                           tset[ti].valset, 1'b1, cap[ti], tset[ti].per && cap[ti],
                           tset[ti].enb, tset[ti].level, 1'b0};
      TGT_TCMP: rd_word = tset[ti].m32 ? {32'b0, cmp[ti][31:0]} : cmp[ti];
      default:  rd_word = '0;
    endcase
  end

  // Comparator write data, truncated in 32-bit mode
  assign wr_cmp = tset[ti].m32 ? {32'b0, cmd.data[31:0]} : cmd.data;

  // Execute the command at the head of the queue
  always_comb begin
    main_count_next = main_count;
    cnt_inc_next    = cnt_inc;
    gen_next        = gen;
    legacy_next     = legacy;
    status_next     = status;
    tset_next       = tset;
    cmp_next        = cmp;
    period_next     = period;
    fire            = '0;
    rd_result       = '0;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (gen) begin
          main_count_next = cnt_inc;
          cnt_inc_next    = cnt_inc + 64'd1;
          for (int n = 0; n < NUM_TIMERS; n++) begin
            if (hit[n]) begin
              fire[n] = tset[n].enb;
              if (tset[n].level) begin
                status_next[n] = 1'b1;
              end
              if (tset[n].per && cap[n]) begin
                cmp_next[n] = tset[n].m32 ? {32'b0, sum[n][31:0]} : sum[n];
              end
            end
          end
        end
      end
      CMD_READ: rd_result = rd_word;
      CMD_WRITE: begin
        unique case (cmd.tgt)
          TGT_GCFG: begin
            gen_next    = cmd.data[0];
            legacy_next = cmd.data[1];
          end
          TGT_GIST: status_next = status & ~cmd.data[NUM_TIMERS-1:0];
          TGT_MCNT: begin
            if (!gen) begin
              main_count_next = cmd.data;
              cnt_inc_next    = cmd.data + 64'd1;
            end
          end
          TGT_TCFG: begin
            tset_next[ti].level  = cmd.data[1];
            tset_next[ti].enb    = cmd.data[2];
            tset_next[ti].per    = cmd.data[3] && cap[ti];
            tset_next[ti].valset = cmd.data[6];
            tset_next[ti].m32    = cmd.data[8];
            tset_next[ti].route  = cmd.data[13:9];
          end
          TGT_TCMP: begin
            if (tset[ti].per && cap[ti]) begin
              period_next[ti] = wr_cmp;
              if (tset[ti].valset) begin
                cmp_next[ti]         = wr_cmp;
                tset_next[ti].valset = 1'b0;
              end
            end else begin
              cmp_next[ti] = wr_cmp;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Level interrupt lines as they stand after this command
  always_comb begin
    for (int n = 0; n < IRQ_W; n++) begin
      irq_next[n] = status_next[n] && tset_next[n].level && tset_next[n].enb;
    end
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      cnt_inc    <= 64'd1;
      gen        <= 1'b0;
      legacy     <= 1'b0;
      status     <= '0;
      out_valid  <= 1'b0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
        tset[n]   <= '0;
        cmp[n]    <= '1;
        period[n] <= '0;
      end
    end else begin
      if (exec) begin
        main_count <= main_count_next;
        cnt_inc    <= cnt_inc_next;
        gen        <= gen_next;
        legacy     <= legacy_next;
        status     <= status_next;
        tset       <= tset_next;
        cmp        <= cmp_next;
        period     <= period_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (exec) begin
      read_data <= rd_result;
      irq_level <= irq_next;
      fired     <= fire[IRQ_W-1:0];
    end
  end

endmodule

// ===== design/hpet_event_timer.sv =====
// Top level of the event timer: decoder, command queue, execution stage and
// configuration registers. Depends on hpet_pkg, hpet_front, hpet_cmdq, hpet_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | in_valid / in_stall  | op, reg_offset, write_data
//   out     | output    | out_valid/out_stall  | read_data, irq_level, fired
//   cfg     | input     | cfg_wen              | cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an item's result
// passes through a queue entry, then the result register, and transfers once
// out_valid is high and out_stall is low.
// In the execution stage the incremented count is kept in a register so the
// compare does not wait on it.
// in_stall rises only when both queue entries are held by a stalled output.
// Reset clears the counter, settings, status and comparators (all ones).
module hpet_event_timer import hpet_pkg::*; #(
  parameter int NUM_TIMERS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [9:0]            reg_offset,
  input  logic [63:0]           write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           read_data,
  output logic [IRQ_W-1:0]      irq_level,
  output logic [IRQ_W-1:0]      fired
);

  logic [PERIOD_FS_W-1:0] tick_period_fs;
  logic [PMASK_W-1:0]     periodic_capable_mask;
  logic [ROUTE_CAP_W-1:0] route_capability;

  cmd_t dec_cmd;
  cmd_t head;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic push;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_fs        <= PERIOD_FS_W'(69841279);
      periodic_capable_mask <= PMASK_W'(7);
      route_capability      <= ROUTE_CAP_W'(4);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TICK_PERIOD: tick_period_fs        <= cfg_wdata[PERIOD_FS_W-1:0];
        CFG_PER_MASK:    periodic_capable_mask <= cfg_wdata[PMASK_W-1:0];
        CFG_ROUTE_CAP:   route_capability      <= cfg_wdata[ROUTE_CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  hpet_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .op         (op),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .cmd        (dec_cmd)
  );

  hpet_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (dec_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  hpet_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk                   (clk),
    .rst                   (rst),
    .tick_period_fs        (tick_period_fs),
    .periodic_capable_mask (periodic_capable_mask),
    .route_capability      (route_capability),
    .q_nonempty            (q_nonempty),
    .cmd                   (head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .read_data             (read_data),
    .irq_level             (irq_level),
    .fired                 (fired)
  );

endmodule

// ===== design/hpet_checker.sv =====
// Port-level checks for the event timer, attached by bind.
// Depends on hpet_pkg and hpet_event_timer.
module hpet_checker import hpet_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [63:0]      read_data,
  input logic [IRQ_W-1:0] fired
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(fired))
    else $error("stalled result changed");

  // No result is shown right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The queue is empty after reset, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // Only ticks fire, and ticks return no read data
  a_fire_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fired != '0) |-> read_data == 64'd0)
    else $error("fired pulse together with read data");

endmodule

bind hpet_event_timer hpet_checker u_hpet_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_data (read_data),
  .fired     (fired)
);

// ===== bench/tb_hpet_event_timer.sv =====
`timescale 1ns / 100ps
// Self-checking bench for hpet_event_timer: directed register and timer cases, then
// random traffic under several capability settings, checked against an in-bench model.
// Depends on hpet_pkg and the hpet_event_timer RTL.
module tb_hpet_event_timer;
  import hpet_pkg::*;

  localparam int NT = 3;
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // register map pieces not in the package
  localparam logic [9:0] OFF_TIMER0   = 10'h100;
  localparam logic [9:0] TIMER_STRIDE = 10'h020;
  localparam logic [9:0] OFF_CMP      = 10'h008;
  localparam logic [9:0] OFF_ROUTE    = 10'h010;
  localparam logic [9:0] OFF_ALIGN    = 10'h3F8;

  // timer config word bits
  localparam int TC_LEVEL    = 1;
  localparam int TC_ENB      = 2;
  localparam int TC_PER      = 3;
  localparam int TC_PERCAP   = 4;
  localparam int TC_64CAP    = 5;
  localparam int TC_VALSET   = 6;
  localparam int TC_M32      = 8;
  localparam int TC_ROUTE_LO = 9;

  // global config and capability words
  localparam int GC_ENABLE = 0;
  localparam int GC_LEGACY = 1;
  localparam logic [63:0] GCFG_STOP = 64'h0;
  localparam logic [63:0] GCFG_RUN  = 64'h1;
  localparam logic [7:0] GCAP_REV = 8'h01;
  localparam int GCAP_CNT64  = 13;
  localparam int GCAP_LEGACY = 15;

  // capability values after reset
  localparam logic [PERIOD_FS_W-1:0] RST_PERIOD_FS = 27'd69841279;
  localparam logic [PMASK_W-1:0]     RST_PMASK     = 3'b111;
  localparam logic [ROUTE_CAP_W-1:0] RST_ROUTE     = 32'd4;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 340;

  typedef struct packed {
    logic [63:0]   rdata;
    logic [IRQ_W-1:0] level;
    logic [IRQ_W-1:0] fire;
  } timer_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_CYCLIC} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [1:0]            cfg_index = CFG_TICK_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            op = OP_TICK;
  logic [9:0]            reg_offset = '0;
  logic [63:0]           write_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [63:0]           read_data;
  logic [IRQ_W-1:0]      irq_level;
  logic [IRQ_W-1:0]      fired;

  // model state: capabilities, counter, per-timer settings
  logic [PERIOD_FS_W-1:0] cap_period_fs;
  logic [PMASK_W-1:0]     cap_periodic;
  logic [ROUTE_CAP_W-1:0] cap_route;
  logic [63:0]            mdl_count;
  logic                   mdl_enable;
  logic                   mdl_legacy;
  logic [NT-1:0]          mdl_status;
  tset_t                  mdl_set [NT];
  logic [63:0]            mdl_cmp [NT];
  logic [63:0]            mdl_period [NT];

  timer_result_t pending_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit steady_feed = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  hpet_event_timer #(.NUM_TIMERS(NT)) dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .reg_offset(reg_offset), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .irq_level(irq_level), .fired(fired)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void model_reset();
    cap_period_fs = RST_PERIOD_FS;
    cap_periodic = RST_PMASK;
    cap_route = RST_ROUTE;
    mdl_count = '0;
    mdl_enable = 1'b0;
    mdl_legacy = 1'b0;
    mdl_status = '0;
    for (int n = 0; n < NT; n++) begin
      mdl_set[n] = '0;
      mdl_cmp[n] = '1;
      mdl_period[n] = '0;
    end
  endfunction

  function automatic void apply_capability(logic [1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_TICK_PERIOD: cap_period_fs = v[PERIOD_FS_W-1:0];
      CFG_PER_MASK:    cap_periodic = v[PMASK_W-1:0];
      CFG_ROUTE_CAP:   cap_route = v[ROUTE_CAP_W-1:0];
      default: ;
    endcase
  endfunction

  // periodic only while the capability bit is still present
  function automatic bit periodic_on(int n);
    return mdl_set[n].per && cap_periodic[n];
  endfunction

  function automatic logic [63:0] timer_config_word(int n);
    logic [63:0] w;
    w = '0;
    w[TC_LEVEL] = mdl_set[n].level;
    w[TC_ENB] = mdl_set[n].enb;
    w[TC_PER] = periodic_on(n);
    w[TC_PERCAP] = cap_periodic[n];
    w[TC_64CAP] = 1'b1;
    w[TC_VALSET] = mdl_set[n].valset;
    w[TC_M32] = mdl_set[n].m32;
    w[TC_ROUTE_LO +: 5] = mdl_set[n].route;
    w[63:32] = cap_route;
    return w;
  endfunction

  function automatic logic [63:0] register_value(logic [9:0] off);
    logic [63:0] v;
    int n;
    v = '0;
    if (off == OFF_GCAP) begin
      v[7:0] = GCAP_REV;
      v[12:8] = 5'(NT - 1);
      v[GCAP_CNT64] = 1'b1;
      v[GCAP_LEGACY] = 1'b1;
      v[63:32] = 32'(cap_period_fs);
    end else if (off == OFF_GCFG) begin
      v[GC_ENABLE] = mdl_enable;
      v[GC_LEGACY] = mdl_legacy;
    end else if (off == OFF_GIST) begin
      v[NT-1:0] = mdl_status;
    end else if (off == OFF_MCNT) begin
      v = mdl_count;
    end else if (off >= OFF_TIMER0) begin
      n = (int'(off) - int'(OFF_TIMER0)) / int'(TIMER_STRIDE);
      if (n < NT) begin
        if (off[4:3] == SUB_CFG) v = timer_config_word(n);
        else if (off[4:3] == SUB_CMP)
          v = mdl_set[n].m32 ? {32'h0, mdl_cmp[n][31:0]} : mdl_cmp[n];
      end
    end
    return v;
  endfunction

  function automatic void apply_write(logic [9:0] off, logic [63:0] d);
    int n;
    if (off == OFF_GCFG) begin
      mdl_enable = d[GC_ENABLE];
      mdl_legacy = d[GC_LEGACY];
    end else if (off == OFF_GIST) begin
      mdl_status = mdl_status & ~d[NT-1:0];
    end else if (off == OFF_MCNT) begin
      if (!mdl_enable) mdl_count = d;
    end else if (off >= OFF_TIMER0) begin
      n = (int'(off) - int'(OFF_TIMER0)) / int'(TIMER_STRIDE);
      if (n < NT && off[4:3] == SUB_CFG) begin
        mdl_set[n].level = d[TC_LEVEL];
        mdl_set[n].enb = d[TC_ENB];
        mdl_set[n].per = d[TC_PER] & cap_periodic[n];
        mdl_set[n].valset = d[TC_VALSET];
        mdl_set[n].m32 = d[TC_M32];
        mdl_set[n].route = d[TC_ROUTE_LO +: 5];
      end else if (n < NT && off[4:3] == SUB_CMP) begin
        if (mdl_set[n].m32) d[63:32] = '0;
        // periodic: load the period, and the comparator too while VAL_SET is up
        if (periodic_on(n)) begin
          mdl_period[n] = d;
          if (mdl_set[n].valset) begin
            mdl_cmp[n] = d;
            mdl_set[n].valset = 1'b0;
          end
        end else begin
          mdl_cmp[n] = d;
        end
      end
    end
  endfunction

  // when enabled, advance the counter and compare every timer against the new count
  function automatic logic [NT-1:0] advance_count();
    logic [NT-1:0] hits;
    logic [63:0] c;
    bit hit;
    hits = '0;
    if (!mdl_enable) return hits;
    mdl_count = mdl_count + 64'd1;
    for (int n = 0; n < NT; n++) begin
      c = mdl_cmp[n];
      hit = mdl_set[n].m32 ? (mdl_count[31:0] == c[31:0]) : (mdl_count == c);
      if (hit) begin
        if (mdl_set[n].enb) hits[n] = 1'b1;
        if (mdl_set[n].level) mdl_status[n] = 1'b1;
        if (periodic_on(n)) begin
          c = c + mdl_period[n];
          mdl_cmp[n] = mdl_set[n].m32 ? {32'h0, c[31:0]} : c;
        end
      end
    end
    return hits;
  endfunction

  function automatic timer_result_t predict_timer_result(logic [1:0] o, logic [9:0] off_raw,
                                                         logic [63:0] d);
    timer_result_t r;
    logic [9:0] off;
    r = '0;
    off = off_raw & OFF_ALIGN;
    case (o)
      OP_TICK:  r.fire = advance_count();
      OP_READ:  r.rdata = register_value(off);
      OP_WRITE: apply_write(off, d);
      default: ;
    endcase
    for (int n = 0; n < NT; n++)
      r.level[n] = mdl_set[n].level & mdl_set[n].enb & mdl_status[n];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, read_data=%h", read_data));
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.rdata)
          report_mismatch($sformatf("read_data %h, want %h", read_data, want.rdata));
        if (irq_level !== want.level)
          report_mismatch($sformatf("irq_level %b, want %b", irq_level, want.level));
        if (fired !== want.fire)
          report_mismatch($sformatf("fired %b, want %b", fired, want.fire));
      end
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall on a changing pattern; a hold request forces a long stretch of stall
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ((mode_left % 8) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- sender

  // offer one item in bursts with gaps; predict its result on transfer
  task automatic send_item(input logic [1:0] o, input logic [9:0] off, input logic [63:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = steady_feed ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    reg_offset <= off;
    write_data <= d;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_timer_result(o, off, d));
  endtask

  // drop valid, wait for every expected result, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capability(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    apply_capability(idx, v);
  endtask

  function automatic logic [9:0] pick_register(logic [9:0] base);
    case ($urandom_range(0, 6))
      0: return OFF_GCAP;
      1: return OFF_GCFG;
      2: return OFF_GIST;
      3: return OFF_MCNT;
      4: return base;
      5: return base + OFF_CMP;
      default: return base + OFF_ROUTE;
    endcase
  endfunction

  // one random item or short well-formed sequence; timer index NT is an absent timer
  task automatic random_item();
    int kind, n;
    logic [63:0] d;
    logic [9:0] base;
    kind = $urandom_range(0, 99);
    n = $urandom_range(0, NT);
    base = OFF_TIMER0 + TIMER_STRIDE * 10'(n);
    d = {$urandom, $urandom};
    if (kind < 45) begin
      send_item(OP_TICK, 10'($urandom), d);
    end else if (kind < 60) begin
      send_item(OP_READ, pick_register(base) | 10'($urandom_range(0, 7)), d);
    end else if (kind < 70) begin
      // aim the comparator just ahead of the count
      if ($urandom_range(0, 3) != 0) d = mdl_count + 64'($urandom_range(1, 12));
      send_item(OP_WRITE, base + OFF_CMP, d);
    end else if (kind < 78) begin
      send_item(OP_WRITE, base, d);
    end else if (kind < 83) begin
      d[GC_ENABLE] = ($urandom_range(0, 9) != 0);
      send_item(OP_WRITE, OFF_GCFG, d);
    end else if (kind < 87) begin
      send_item(OP_WRITE, OFF_GIST, d);
    end else if (kind < 91) begin
      // stop, reload the counter near a wrap point, restart
      send_item(OP_WRITE, OFF_GCFG, GCFG_STOP);
      case ($urandom_range(0, 2))
        0: d = {32'h0, 32'hFFFF_FFFF - 32'($urandom_range(0, 15))};
        1: d = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
        default: ;
      endcase
      send_item(OP_WRITE, OFF_MCNT, d);
      send_item(OP_WRITE, OFF_GCFG, GCFG_RUN);
    end else if (kind < 96) begin
      send_item(2'($urandom), 10'($urandom), d);
    end else begin
      // arm a periodic timer: first value loads both, second the period only
      d = '0;
      d[TC_LEVEL] = 1'($urandom_range(0, 1));
      d[TC_ENB] = 1'b1;
      d[TC_PER] = 1'b1;
      d[TC_VALSET] = 1'b1;
      d[TC_M32] = ($urandom_range(0, 3) == 0);
      send_item(OP_WRITE, base, d);
      send_item(OP_WRITE, base + OFF_CMP, mdl_count + 64'($urandom_range(1, 8)));
      send_item(OP_WRITE, base + OFF_CMP, 64'($urandom_range(1, 10)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_item(OP_READ, OFF_GCAP, '0);
    send_item(OP_READ, OFF_GCFG, '1);
    send_item(OP_READ, OFF_GIST, '0);
    send_item(OP_READ, OFF_MCNT | 10'h007, '0);
    send_item(OP_READ, OFF_TIMER0, '0);
    send_item(OP_READ, OFF_TIMER0 + TIMER_STRIDE + OFF_CMP, '0);
    send_item(OP_READ, OFF_TIMER0 + 10'd2 * TIMER_STRIDE + OFF_ROUTE, '0);
    send_item(OP_READ, 10'h3FF, '0);
    send_item(OP_WRITE, OFF_GCAP, '1);
    send_item(OP_READ, OFF_GCAP, '0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_IDLE, 10'h3FF, '1);
  endtask

  task automatic test_one_shot_match();
    logic [63:0] d;
    send_item(OP_WRITE, OFF_MCNT, 64'hFFFF_FFFF_FFFF_FFFE);
    d = '0;
    d[TC_LEVEL] = 1'b1;
    d[TC_ENB] = 1'b1;
    send_item(OP_WRITE, OFF_TIMER0, d);
    d = '0;
    d[TC_ENB] = 1'b1;
    d[TC_M32] = 1'b1;
    send_item(OP_WRITE, OFF_TIMER0 + TIMER_STRIDE, d);
    send_item(OP_WRITE, OFF_TIMER0 + TIMER_STRIDE + OFF_CMP, '1);
    send_item(OP_WRITE, OFF_GCFG, 64'h3);
    // both match on the all-ones count, then the counter wraps
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '1, '1);
    send_item(OP_WRITE, OFF_MCNT, '0);
    send_item(OP_READ, OFF_MCNT, '0);
    send_item(OP_WRITE, OFF_GIST, '1);
  endtask

  task automatic test_periodic();
    logic [63:0] d;
    d = '0;
    d[TC_LEVEL] = 1'b1;
    d[TC_ENB] = 1'b1;
    d[TC_PER] = 1'b1;
    d[TC_VALSET] = 1'b1;
    send_item(OP_WRITE, OFF_TIMER0 + 10'd2 * TIMER_STRIDE, d);
    send_item(OP_WRITE, OFF_TIMER0 + 10'd2 * TIMER_STRIDE + OFF_CMP, 64'd3);
    send_item(OP_WRITE, OFF_TIMER0 + 10'd2 * TIMER_STRIDE + OFF_CMP, 64'd2);
    repeat (5) send_item(OP_TICK, '0, '0);
    send_item(OP_READ, OFF_TIMER0 + 10'd2 * TIMER_STRIDE, '0);
  endtask

  // random traffic under extreme and random capability settings
  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_capability(CFG_TICK_PERIOD, 32'd1);
          write_capability(CFG_PER_MASK, '0);
          write_capability(CFG_ROUTE_CAP, '0);
        end
        1: begin
          write_capability(CFG_TICK_PERIOD, 32'd100000000);
          write_capability(CFG_PER_MASK, 32'd7);
          write_capability(CFG_ROUTE_CAP, '1);
          write_capability(CFG_UNUSED, '1);
        end
        default: begin
          write_capability(CFG_TICK_PERIOD, $urandom);
          write_capability(CFG_PER_MASK, $urandom);
          write_capability(CFG_ROUTE_CAP, $urandom);
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end
  endtask

  // hold the output off while feeding without gaps so the input backs up
  task automatic test_backpressure();
    wait_drained();
    steady_feed = 1'b1;
    burst_left = 0;
    hold_req++;
    repeat (24) random_item();
    steady_feed = 1'b0;
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_one_shot_match();
    test_periodic();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
